[hdl/hecs_pkg.sv]
// Shared constants and types for the histogram equalizer / contrast stretcher.
`default_nettype none
package hecs_pkg;
  localparam int CHANNELS = 3;
  localparam int BINS = 256;
  localparam int MAX_DIM = 4096;
  localparam int CNT_W = 25;
  localparam int PIX_W = 8;
  localparam int DIM_W = 13;
  localparam int TOT_W = 25;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [DIM_W-1:0] MAX_DIM_V = 13'd4096;

  localparam logic [1:0] REG_METHOD = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_CHANNELS = 2'd3;

  typedef struct packed {
    logic clr;
    logic build;
    logic [PIX_W-1:0] bin;
    logic method;
    logic [TOT_W-1:0] total;
  } lane_ctl_t;
endpackage
`default_nettype wire

[hdl/hecs_div.sv]
// Restoring divider: 33-bit dividend by 25-bit divisor, one quotient bit per cycle.
`default_nettype none
module hecs_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] dividend,
  input  wire logic [24:0] divisor,
  output logic             done,
  output logic [7:0]       quot
);
  logic [32:0] q_r, q_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [24:0] dv_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [25:0] sh;
  logic        done_nxt;

  always_comb begin
    sh = {rem_r[24:0], q_r[32]};
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt = dividend;
      cnt_nxt = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, dv_r}) begin
        rem_nxt = sh - {1'b0, dv_r};
        q_nxt = {q_r[31:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (start) dv_r <= divisor;
  end

  assign quot = (q_r[32:8] != '0) ? 8'd255 : q_r[7:0];
endmodule
`default_nettype wire

[hdl/hecs_lane.sv]
// One channel lane: histogram, min/max tracking, map table build and lookup.
`default_nettype none
module hecs_lane (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   gather,
  input  wire logic                   lookup,
  input  wire logic [7:0]             pix,
  input  wire hecs_pkg::lane_ctl_t    ctl,
  output logic                        step_done,
  output logic [7:0]                  map_out
);
  typedef enum logic [2:0] {L_IDLE, L_RD, L_ADD, L_DIV, L_WR} lst_t;

  logic [hecs_pkg::CNT_W-1:0] hist_mem [hecs_pkg::BINS];
  logic [7:0]                 map_mem  [hecs_pkg::BINS];
  logic [hecs_pkg::BINS-1:0]  hv_r;
  logic [7:0] min_r, max_r;
  logic [hecs_pkg::CNT_W-1:0] rd_r, sum_r;
  logic [7:0] gpix_r;
  logic       gval_r;
  lst_t       st_r;
  logic [7:0] mval_r;
  logic       dstart_r, ddone;
  logic [32:0] dvd_r;
  logic [24:0] dvs_r;
  logic [7:0]  dq;
  logic [hecs_pkg::CNT_W-1:0] cur, inc, sum_nxt;
  logic [25:0] sumw;
  logic [7:0] span;
  logic [7:0] off;

  hecs_div u_div (.clk, .rst_n, .start(dstart_r), .dividend(dvd_r), .divisor(dvs_r),
                  .done(ddone), .quot(dq));

  assign cur = hv_r[gpix_r] ? rd_r : '0;
  assign inc = (cur == hecs_pkg::COUNT_MAX) ? cur : cur + 25'd1;
  assign sumw = {1'b0, sum_r} + {1'b0, (hv_r[ctl.bin] ? rd_r : 25'd0)};
  assign sum_nxt = sumw[25] ? hecs_pkg::COUNT_MAX : sumw[24:0];
  assign span = max_r - min_r;
  assign off = ctl.bin - min_r;

  // gather: read into rd_r, write back while gval_r is set; forward on back-to-back same bin
  logic       fwd;
  assign fwd = gval_r && gather && (pix == gpix_r);
  logic [hecs_pkg::CNT_W-1:0] fwd_r;
  logic       fwd_v_r;

  always_ff @(posedge clk) begin
    if (gather) rd_r <= hist_mem[pix];
    else if (st_r == L_RD) rd_r <= hist_mem[ctl.bin];
    if (gval_r) hist_mem[gpix_r] <= fwd_v_r ? fwd_r : inc;
    if (st_r == L_WR) map_mem[ctl.bin] <= mval_r;
    if (lookup) map_out <= map_mem[pix];
    gpix_r <= pix;
  end

  logic [hecs_pkg::CNT_W-1:0] gcur;
  assign gcur = fwd_v_r ? fwd_r : inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
      min_r <= 8'd255;
      max_r <= 8'd0;
      gval_r <= 1'b0;
      fwd_v_r <= 1'b0;
      st_r <= L_IDLE;
      step_done <= 1'b0;
      dstart_r <= 1'b0;
      sum_r <= '0;
    end else begin
      gval_r <= gather;
      fwd_v_r <= 1'b0;
      if (gval_r) begin
        hv_r[gpix_r] <= 1'b1;
        if (fwd) begin
          fwd_v_r <= 1'b1;
          fwd_r <= (gcur == hecs_pkg::COUNT_MAX) ? gcur : gcur + 25'd1;
        end
      end
      if (gather) begin
        if (pix < min_r) min_r <= pix;
        if (pix > max_r) max_r <= pix;
      end
      step_done <= 1'b0;
      dstart_r <= 1'b0;
      case (st_r)
        L_IDLE: if (ctl.build) st_r <= L_RD;
        L_RD: st_r <= L_ADD;
        L_ADD: begin
          if (ctl.method) begin
            sum_r <= sum_nxt;
            dvd_r <= {8'd0, sum_nxt} * 33'd255;
            dvs_r <= ctl.total;
            if (ctl.total == '0) begin
              mval_r <= 8'd0;
              st_r <= L_WR;
            end else begin
              dstart_r <= 1'b1;
              st_r <= L_DIV;
            end
          end else if (max_r <= min_r || ctl.bin <= min_r) begin
            mval_r <= 8'd0;
            st_r <= L_WR;
          end else if (ctl.bin >= max_r) begin
            mval_r <= 8'd255;
            st_r <= L_WR;
          end else begin
            dvd_r <= {25'd0, off} * 33'd255;
            dvs_r <= {17'd0, span};
            dstart_r <= 1'b1;
            st_r <= L_DIV;
          end
        end
        L_DIV: if (ddone) begin
          mval_r <= dq;
          st_r <= L_WR;
        end
        L_WR: begin
          step_done <= 1'b1;
          st_r <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
      if (ctl.clr) begin
        hv_r <= '0;
        min_r <= 8'd255;
        max_r <= 8'd0;
        sum_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/histogram_equalizer_contrast_stretch_top.sv]
// Top level: input control, three channel lanes and output merge.
// Gather words: one per cycle unless in_stall is set. Map words: a word right behind a map word
// is stalled while the lookup is in flight; map_out is registered in the lanes, then out_valid.
// Last gather word starts a table build over all 256 bins (divider: one quotient bit per
// cycle, 33 bits per entry); input stalls meanwhile.
// Synchronous active-low reset: registers return to method 1, 512x512, 3 channels;
// histograms empty, min 255, max 0. Map table undefined until first build.
`default_nettype none
module histogram_equalizer_contrast_stretch_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_chan0_value,
  input  wire logic [7:0]  in_chan1_value,
  input  wire logic [7:0]  in_chan2_value,
  input  wire logic        in_last_pixel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_chan0,
  output logic [7:0]       out_chan1,
  output logic [7:0]       out_chan2,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  typedef enum logic [1:0] {S_RUN, S_BUILD, S_WAIT, S_NEXT} st_t;
  st_t st_r;
  logic        method_r;
  logic [12:0] w_r, h_r;
  logic [1:0]  ch_r;
  logic [7:0]  bin_r;
  logic        lk_r;
  logic [1:0]  lanes;
  logic [2:0]  act_r;
  logic [2:0]  act;
  logic [2:0]  dn_r;
  logic        acc, gath, look;
  logic [2:0]  sdone;
  logic [7:0]  mo [3];
  logic [12:0] wc, hc;
  logic [24:0] tot;
  hecs_pkg::lane_ctl_t ctl [3];
  logic        build_go, clr_go;

  assign lanes = ch_r;
  assign wc = (w_r > hecs_pkg::MAX_DIM_V) ? hecs_pkg::MAX_DIM_V : w_r;
  assign hc = (h_r > hecs_pkg::MAX_DIM_V) ? hecs_pkg::MAX_DIM_V : h_r;
  assign tot = 25'(wc * hc);

  // stall while building, behind a lookup in flight, or while the output is blocked
  assign in_stall = (st_r != S_RUN) || lk_r || (out_valid && out_stall);
  assign acc = in_valid && !in_stall;
  assign gath = acc && !in_action;
  assign look = acc && in_action;
  assign build_go = (st_r == S_BUILD);
  assign clr_go = (st_r == S_NEXT) && (bin_r == 8'd255);
  assign act = {lanes == 2'd3, lanes >= 2'd2, lanes >= 2'd1};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ctl[c].clr = clr_go;
      ctl[c].build = build_go && act[c];
      ctl[c].bin = bin_r;
      ctl[c].method = method_r;
      ctl[c].total = tot;
    end
  end

  hecs_lane u_l0 (.clk, .rst_n, .gather(gath && act[0]), .lookup(look), .pix(in_chan0_value),
                  .ctl(ctl[0]), .step_done(sdone[0]), .map_out(mo[0]));
  hecs_lane u_l1 (.clk, .rst_n, .gather(gath && act[1]), .lookup(look), .pix(in_chan1_value),
                  .ctl(ctl[1]), .step_done(sdone[1]), .map_out(mo[1]));
  hecs_lane u_l2 (.clk, .rst_n, .gather(gath && act[2]), .lookup(look), .pix(in_chan2_value),
                  .ctl(ctl[2]), .step_done(sdone[2]), .map_out(mo[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b1;
      w_r <= 13'd512;
      h_r <= 13'd512;
      ch_r <= 2'd3;
      st_r <= S_RUN;
      bin_r <= '0;
      lk_r <= 1'b0;
      out_valid <= 1'b0;
      act_r <= '0;
      dn_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hecs_pkg::REG_METHOD: method_r <= cfg_data[0];
          hecs_pkg::REG_WIDTH: w_r <= cfg_data;
          hecs_pkg::REG_HEIGHT: h_r <= cfg_data;
          hecs_pkg::REG_CHANNELS: ch_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      lk_r <= look;
      if (look) act_r <= act;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (lk_r) begin
        out_valid <= 1'b1;
        out_chan0 <= act_r[0] ? mo[0] : 8'd0;
        out_chan1 <= act_r[1] ? mo[1] : 8'd0;
        out_chan2 <= act_r[2] ? mo[2] : 8'd0;
      end
      case (st_r)
        S_RUN: if (gath && in_last_pixel) begin
          bin_r <= '0;
          st_r <= S_BUILD;
        end
        S_BUILD: begin
          dn_r <= '0;
          st_r <= S_WAIT;
        end
        S_WAIT: begin
          if (&(dn_r | sdone | ~act)) st_r <= S_NEXT;
          else dn_r <= dn_r | sdone;
        end
        S_NEXT: begin
          if (bin_r == 8'd255) st_r <= S_RUN;
          else begin
            bin_r <= bin_r + 8'd1;
            st_r <= S_BUILD;
          end
        end
        default: st_r <= S_RUN;
      endcase
    end
  end
endmodule
`default_nettype wire
